// ----- rtl/pafr_pkg.sv -----
// Package: shared types, constants and codes of the per-atom force reducer.
package pafr_pkg;

	localparam int unsigned NumAtomsDef = 1024;
	localparam int unsigned IdxW = 10;
	localparam int unsigned ValW = 32;
	localparam int unsigned CntW = 16;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACCUM = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RED_SUM = 2'd0,
		RED_MAX = 2'd1,
		RED_MIN = 2'd2,
		RED_AVG = 2'd3
	} red_t;

	localparam logic REG_REDUCE = 1'b0;
	localparam logic REG_SCALAR = 1'b1;

	// Command handed from the front part to the back part.
	typedef struct packed {
		op_t              op;
		logic [IdxW-1:0]  atom_a;
		logic [IdxW-1:0]  atom_b;
		logic [ValW-1:0]  scalar;
	} cmd_t;

	typedef enum logic [2:0] {
		FS_IDLE, FS_SQ, FS_SQRT_F, FS_SQRT_S, FS_DIV, FS_PUSH
	} fstate_t;

	typedef enum logic [3:0] {
		BS_IDLE, BS_CLEAR, BS_RD, BS_WAIT, BS_UPD, BS_DIV, BS_OUT
	} bstate_t;

endpackage

// ----- rtl/pafr_if.sv -----
// Interfaces: input item, result item and configuration write channels.
interface pafr_in_if;
	import pafr_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             operation;
	logic [IdxW-1:0]        atom_a;
	logic [IdxW-1:0]        atom_b;
	logic signed [31:0]     force_x;
	logic signed [31:0]     force_y;
	logic signed [31:0]     force_z;
	logic signed [31:0]     sep_x;
	logic signed [31:0]     sep_y;
	logic signed [31:0]     sep_z;
	modport source (output valid, operation, atom_a, atom_b, force_x, force_y, force_z,
		sep_x, sep_y, sep_z, input ready);
	modport sink (input valid, operation, atom_a, atom_b, force_x, force_y, force_z,
		sep_x, sep_y, sep_z, output ready);
endinterface

interface pafr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] atom_value;
	logic [15:0] pair_count;
	modport source (output valid, atom_value, pair_count, input ready);
	modport sink (input valid, atom_value, pair_count, output ready);
endinterface

interface pafr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pafr_divider.sv -----
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module pafr_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] num_q;
	logic [32:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], num_q[63]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				num_q <= {num_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = num_q;
endmodule

// ----- rtl/pafr_front.sv -----
// Front part: take items, form the force scalar, push commands to the queue.
module pafr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scalar_mode,
	pafr_in_if.sink           in_ch,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output pafr_pkg::cmd_t    cmd
);
	import pafr_pkg::*;

	fstate_t st_q, st_d;
	cmd_t    cmd_q;
	logic [31:0] f_q [3];
	logic [31:0] s_q [3];
	logic [2:0]  fneg_q, sneg_q;
	logic [1:0]  k_q;
	logic [65:0] fsq_q, ssq_q;
	logic [65:0] pos_q, neg_q;
	logic [63:0] rad_q, res_q, bit_q;
	logic [31:0] flen_q;
	logic        div_start;
	logic        div_done;
	logic [63:0] quot;
	logic [63:0] dot;
	logic [63:0] pf, ps, pd;
	logic [63:0] sum_rb;
	logic        take;
	logic        ssq_zero;

	assign in_ch.ready = (st_q == FS_IDLE);
	assign take = in_ch.valid && in_ch.ready;
	assign pf = f_q[k_q] * f_q[k_q];
	assign ps = s_q[k_q] * s_q[k_q];
	assign pd = f_q[k_q] * s_q[k_q];
	assign sum_rb = res_q + bit_q;
	assign dot = (pos_q >= neg_q) ? 64'(pos_q - neg_q) : 64'(neg_q - pos_q);
	assign ssq_zero = (ssq_q == '0);

	pafr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dot),
		.divisor(res_q[31:0]), .done(div_done), .quotient(quot)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			FS_IDLE:   if (take) st_d = (op_t'(in_ch.operation) == OP_ACCUM) ? FS_SQ : FS_PUSH;
			FS_SQ:     if (k_q == 2'd2) st_d = FS_SQRT_F;
			FS_SQRT_F: if (bit_q == '0)
				st_d = (scalar_mode && !ssq_zero) ? FS_SQRT_S : FS_PUSH;
			FS_SQRT_S: if (bit_q == '0) st_d = (res_q == '0) ? FS_PUSH : FS_DIV;
			FS_DIV:    if (div_done) st_d = FS_PUSH;
			FS_PUSH:   if (cmd_ready) st_d = FS_IDLE;
			default:   st_d = FS_IDLE;
		endcase
	end

	always_comb begin
		div_start = (st_q == FS_SQRT_S) && (bit_q == '0) && (res_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FS_IDLE;
		else         st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			FS_IDLE: if (take) begin
				cmd_q.op     <= op_t'(in_ch.operation);
				cmd_q.atom_a <= in_ch.atom_a;
				cmd_q.atom_b <= in_ch.atom_b;
				cmd_q.scalar <= '0;
				f_q[0] <= in_ch.force_x[31] ? -in_ch.force_x : in_ch.force_x;
				f_q[1] <= in_ch.force_y[31] ? -in_ch.force_y : in_ch.force_y;
				f_q[2] <= in_ch.force_z[31] ? -in_ch.force_z : in_ch.force_z;
				s_q[0] <= in_ch.sep_x[31] ? -in_ch.sep_x : in_ch.sep_x;
				s_q[1] <= in_ch.sep_y[31] ? -in_ch.sep_y : in_ch.sep_y;
				s_q[2] <= in_ch.sep_z[31] ? -in_ch.sep_z : in_ch.sep_z;
				fneg_q <= {in_ch.force_z[31], in_ch.force_y[31], in_ch.force_x[31]};
				sneg_q <= {in_ch.sep_z[31], in_ch.sep_y[31], in_ch.sep_x[31]};
				k_q   <= 2'd0;
				fsq_q <= '0; ssq_q <= '0; pos_q <= '0; neg_q <= '0;
			end
			FS_SQ: begin
				fsq_q <= fsq_q + 66'(pf);
				ssq_q <= ssq_q + 66'(ps);
				if (fneg_q[k_q] != sneg_q[k_q]) neg_q <= neg_q + 66'(pd);
				else                            pos_q <= pos_q + 66'(pd);
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2) begin
					// sum of three squares of magnitudes < 2^64
					rad_q <= 64'(fsq_q + 66'(pf));
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			FS_SQRT_F, FS_SQRT_S: begin
				if (bit_q != '0) begin
					if (rad_q >= sum_rb) begin
						rad_q <= rad_q - sum_rb;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (st_q == FS_SQRT_F) begin
					flen_q       <= res_q[31:0];
					cmd_q.scalar <= res_q[31:0];
					if (scalar_mode && !ssq_zero) begin
						rad_q <= 64'(ssq_q);
						res_q <= '0;
						bit_q <= 64'h4000_0000_0000_0000;
					end
				end else if (res_q == '0) begin
					cmd_q.scalar <= flen_q;
				end
			end
			FS_DIV: if (div_done)
				cmd_q.scalar <= (quot[63:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
			default: ;
		endcase
	end

	assign cmd_valid = (st_q == FS_PUSH);
	assign cmd = cmd_q;
endmodule

// ----- rtl/pafr_queue.sv -----
// Two-entry command queue between front and back parts.
module pafr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pafr_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output pafr_pkg::cmd_t out_cmd
);
	import pafr_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;
	assign out_cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end
endmodule

// ----- rtl/pafr_back.sv -----
// Back part: per-atom stores, clear sweep, fold and readout.
module pafr_back #(
	parameter int unsigned NUM_ATOMS = pafr_pkg::NumAtomsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     reduce_mode,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  pafr_pkg::cmd_t cmd,
	pafr_out_if.source     out_ch
);
	import pafr_pkg::*;

	localparam int unsigned AW = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;

	logic [31:0] val_mem [NUM_ATOMS];
	logic [15:0] cnt_mem [NUM_ATOMS];

	bstate_t st_q, st_d;
	cmd_t    c_q;
	logic    second_q;
	logic [AW:0] clr_q;
	logic [31:0] rv_q;
	logic [15:0] rc_q;
	logic [31:0] ov_q;
	logic [15:0] oc_q;
	logic        ovalid_q;
	logic [IdxW-1:0] idx;
	logic        idx_ok;
	logic [AW-1:0] addr;
	logic        we;
	logic [31:0] wv;
	logic [32:0] sum;
	logic        div_start, div_done;
	logic [63:0] quot;

	assign idx    = second_q ? c_q.atom_b : c_q.atom_a;
	assign idx_ok = ({{(AW+1){1'b0}}, idx} < (AW+1+IdxW)'(NUM_ATOMS));
	assign addr   = (st_q == BS_CLEAR) ? clr_q[AW-1:0] : AW'(idx);
	assign sum    = {1'b0, rv_q} + {1'b0, c_q.scalar};
	assign cmd_ready = (st_q == BS_IDLE);

	always_comb begin
		unique case (red_t'(reduce_mode))
			RED_MAX: wv = (c_q.scalar > rv_q) ? c_q.scalar : rv_q;
			RED_MIN: wv = (rv_q == '0 || c_q.scalar < rv_q) ? c_q.scalar : rv_q;
			default: wv = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		endcase
	end

	assign we = (st_q == BS_CLEAR) || (st_q == BS_UPD);

	pafr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend({32'd0, rv_q}),
		.divisor({16'd0, rc_q}), .done(div_done), .quotient(quot)
	);

	always_comb begin
		st_d = st_q;
		div_start = 1'b0;
		unique case (st_q)
			BS_IDLE: if (cmd_valid) begin
				unique case (cmd.op)
					OP_CLEAR: st_d = BS_CLEAR;
					OP_ACCUM: st_d = BS_RD;
					OP_READ:  st_d = BS_RD;
					default:  st_d = BS_IDLE;
				endcase
			end
			BS_CLEAR: if (clr_q == (AW+1)'(NUM_ATOMS - 1)) st_d = BS_IDLE;
			BS_RD:   st_d = idx_ok ? BS_WAIT : ((c_q.op == OP_READ) ? BS_OUT :
				(second_q ? BS_IDLE : BS_RD));
			BS_WAIT: begin
				if (c_q.op == OP_ACCUM) st_d = BS_UPD;
				else if (red_t'(reduce_mode) == RED_AVG && rc_q > 16'd1) begin
					st_d = BS_DIV;
					div_start = 1'b1;
				end else st_d = BS_OUT;
			end
			BS_UPD:  st_d = second_q ? BS_IDLE : BS_RD;
			BS_DIV:  if (div_done) st_d = BS_OUT;
			BS_OUT:  if (!ovalid_q || out_ch.ready) st_d = BS_IDLE;
			default: st_d = BS_IDLE;
		endcase
	end

	// Leave reset in the clear sweep so both stores read zero before the first command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BS_CLEAR;
			second_q <= 1'b0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BS_OUT && (!ovalid_q || out_ch.ready)) ovalid_q <= 1'b1;
			else if (out_ch.ready)                             ovalid_q <= 1'b0;
			unique case (st_q)
				BS_IDLE:  begin second_q <= 1'b0; clr_q <= '0; end
				BS_CLEAR: clr_q <= clr_q + 1'b1;
				BS_RD:    if (!idx_ok && c_q.op != OP_READ) second_q <= 1'b1;
				BS_UPD:   second_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BS_IDLE && cmd_valid) c_q <= cmd;
		if (st_q == BS_RD) begin
			if (idx_ok) begin
				rv_q <= val_mem[addr];
				rc_q <= cnt_mem[addr];
			end else begin
				rv_q <= '0; rc_q <= '0;
			end
		end
		if (we) begin
			val_mem[addr] <= (st_q == BS_CLEAR) ? 32'd0 : wv;
			cnt_mem[addr] <= (st_q == BS_CLEAR) ? 16'd0 :
				((rc_q == 16'hFFFF) ? rc_q : rc_q + 16'd1);
		end
		if (st_q == BS_WAIT && c_q.op == OP_READ && red_t'(reduce_mode) == RED_AVG
			&& rc_q == 16'd0) rv_q <= '0;
		if (st_q == BS_DIV && div_done) rv_q <= quot[31:0];
		if (st_q == BS_OUT && (!ovalid_q || out_ch.ready)) begin
			ov_q <= rv_q; oc_q <= rc_q;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.atom_value = ov_q;
	assign out_ch.pair_count = oc_q;
endmodule

// ----- rtl/per_atom_force_reducer_core.sv -----
// Top level: per-atom force reducer, front scalar unit, queue and store unit.
// Front steps: a norm pair runs the three square sums, the root steps, push and idle; projection
// mode may add a second root and a divide; other items go straight to push. Back: each atom of
// a pair is read then updated; a read may divide for the average before output; a clear sweeps all.
// One item at a time in each part; the two-entry queue lets the parts overlap.
// arst_n low resets modes and control; the back then sweeps both stores to zero.
module per_atom_force_reducer_core #(
	parameter int unsigned NUM_ATOMS = pafr_pkg::NumAtomsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	pafr_in_if.sink    in_ch,
	pafr_out_if.source out_ch,
	pafr_cfg_if.sink   cfg
);
	import pafr_pkg::*;

	logic [1:0] reduce_mode_q;
	logic       scalar_mode_q;
	logic       f_valid, f_ready, b_valid, b_ready;
	cmd_t       f_cmd, b_cmd;

	// Configuration transfers are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduce_mode_q <= RED_SUM;
			scalar_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_REDUCE) reduce_mode_q <= cfg.data;
			else                         scalar_mode_q <= cfg.data[0];
		end
	end

	pafr_front u_front (
		.clk(clk), .arst_n(arst_n), .scalar_mode(scalar_mode_q), .in_ch(in_ch),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pafr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
	);

	pafr_back #(.NUM_ATOMS(NUM_ATOMS)) u_back (
		.clk(clk), .arst_n(arst_n), .reduce_mode(reduce_mode_q),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd), .out_ch(out_ch)
	);
endmodule

// ----- rtl/pafr_checker.sv -----
// Checker: port-level properties of the reducer, bound to the top level.
module pafr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_op,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value
);
	import pafr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result dropped under stall");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == OP_READ |=> !(in_valid && in_ready))
		else $error("item taken right after a read");
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result present during reset");
endmodule

bind per_atom_force_reducer_core pafr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_op(in_ch.operation), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_value(out_ch.atom_value)
);
